// ===== sv/tkc_pkg.sv =====
// Shared types, key codes and escape-sequence decoding for the terminal key cursor tracker.
package tkc_pkg;

    localparam int KEY_W     = 9;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [7:0]       t_byte;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LINES = 2'd2;

    localparam logic [COL_W-1:0] RESET_ROWS  = 10'd24;
    localparam logic [COL_W-1:0] RESET_COLS  = 10'd80;
    localparam logic [ROW_W-1:0] RESET_LINES = 16'd0;

    // Input operation codes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Bytes of interest.
    localparam t_byte BYTE_ESC      = 8'h1b;
    localparam t_byte BYTE_LBRACKET = 8'h5b;
    localparam t_byte BYTE_O        = 8'h4f;
    localparam t_byte BYTE_TILDE    = 8'h7e;
    localparam t_byte BYTE_A        = 8'h41;
    localparam t_byte BYTE_B        = 8'h42;
    localparam t_byte BYTE_C        = 8'h43;
    localparam t_byte BYTE_D        = 8'h44;
    localparam t_byte BYTE_F        = 8'h46;
    localparam t_byte BYTE_H        = 8'h48;
    localparam t_byte BYTE_DIG_0    = 8'h30;
    localparam t_byte BYTE_DIG_1    = 8'h31;
    localparam t_byte BYTE_DIG_3    = 8'h33;
    localparam t_byte BYTE_DIG_4    = 8'h34;
    localparam t_byte BYTE_DIG_5    = 8'h35;
    localparam t_byte BYTE_DIG_6    = 8'h36;
    localparam t_byte BYTE_DIG_7    = 8'h37;
    localparam t_byte BYTE_DIG_8    = 8'h38;
    localparam t_byte BYTE_DIG_9    = 8'h39;

    // Key codes.
    localparam t_key KEY_ESC    = 9'd27;
    localparam t_key KEY_CTRL_Q = 9'h011;
    localparam t_key KEY_LEFT   = 9'd256;
    localparam t_key KEY_RIGHT  = 9'd257;
    localparam t_key KEY_UP     = 9'd258;
    localparam t_key KEY_DOWN   = 9'd259;
    localparam t_key KEY_DELETE = 9'd260;
    localparam t_key KEY_HOME   = 9'd261;
    localparam t_key KEY_END    = 9'd262;
    localparam t_key KEY_PGUP   = 9'd263;
    localparam t_key KEY_PGDN   = 9'd264;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_FIRST,
        PH_DIGIT
    } t_phase;

    // A decoded key travelling from the parser into the queue.
    typedef struct packed {
        logic push;
        t_key key;
    } t_key_push;

    // Live configuration seen by the cursor unit.
    typedef struct packed {
        logic [COL_W-1:0] rows;
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] lines;
    } t_cfg;

    function automatic t_key decode_two(input t_byte a, input t_byte b);
        t_key k;
        k = KEY_ESC;
        if (a == BYTE_LBRACKET) begin
            unique case (b)
                BYTE_A:  k = KEY_UP;
                BYTE_B:  k = KEY_DOWN;
                BYTE_C:  k = KEY_RIGHT;
                BYTE_D:  k = KEY_LEFT;
                BYTE_H:  k = KEY_HOME;
                BYTE_F:  k = KEY_END;
                default: k = KEY_ESC;
            endcase
        end else if (a == BYTE_O) begin
            if (b == BYTE_H) begin
                k = KEY_HOME;
            end else if (b == BYTE_F) begin
                k = KEY_END;
            end
        end
        return k;
    endfunction

    function automatic t_key decode_digit(input t_byte d);
        t_key k;
        unique case (d)
            BYTE_DIG_1: k = KEY_HOME;
            BYTE_DIG_3: k = KEY_DELETE;
            BYTE_DIG_4: k = KEY_END;
            BYTE_DIG_5: k = KEY_PGUP;
            BYTE_DIG_6: k = KEY_PGDN;
            BYTE_DIG_7: k = KEY_HOME;
            BYTE_DIG_8: k = KEY_END;
            default:    k = KEY_ESC;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/tkc_front.sv =====
// Escape-sequence parser: classifies each accepted beat and pushes completed keys.
module tkc_front
    import tkc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic      i_operation,
    input  t_byte     i_in_byte,
    output t_key_push o_push
);

    t_phase r_phase, n_phase;
    t_byte  r_first, n_first;
    t_byte  r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
        r_first  <= n_first;
        r_second <= n_second;
    end

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_second    = r_second;
        o_push.push = 1'b0;
        o_push.key  = KEY_ESC;
        if (i_accept) begin
            if (i_operation == OP_TIMEOUT) begin
                // A timeout abandons any open sequence and yields ESC.
                if (r_phase != PH_IDLE) begin
                    n_phase     = PH_IDLE;
                    o_push.push = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_in_byte == BYTE_ESC) begin
                            n_phase = PH_ESC;
                        end else begin
                            o_push.push = 1'b1;
                            o_push.key  = KEY_W'(i_in_byte);
                        end
                    end
                    PH_ESC: begin
                        n_first = i_in_byte;
                        n_phase = PH_FIRST;
                    end
                    PH_FIRST: begin
                        n_second = i_in_byte;
                        if (r_first == BYTE_LBRACKET && i_in_byte >= BYTE_DIG_0
                            && i_in_byte <= BYTE_DIG_9) begin
                            n_phase = PH_DIGIT;
                        end else begin
                            n_phase     = PH_IDLE;
                            o_push.push = 1'b1;
                            o_push.key  = decode_two(r_first, i_in_byte);
                        end
                    end
                    PH_DIGIT: begin
                        n_phase     = PH_IDLE;
                        o_push.push = 1'b1;
                        o_push.key  = (i_in_byte == BYTE_TILDE) ? decode_digit(r_second)
                                                                 : KEY_ESC;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/tkc_queue.sv =====
// Short key queue between the parser and the cursor unit.
module tkc_queue
    import tkc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_key_push i_push,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_key      o_key
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_key          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_key    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push.push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CW'(i_push.push) - CW'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.key;
        end
    end

endmodule

// ===== sv/tkc_back.sv =====
// Cursor unit: applies each key to the cursor and view, and holds the result register.
module tkc_back
    import tkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_key_valid,
    input  t_key             i_key,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_key             o_key_code,
    output logic             o_quit,
    output logic [COL_W-1:0] o_cursor_col,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [ROW_W-1:0] o_top_row
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_top, n_top;
    logic             r_out_valid;
    t_key             r_key;
    logic             r_quit;

    logic [COL_W-1:0] w_rows;
    logic [COL_W-1:0] w_cols;
    logic [ROW_W-1:0] w_rows16;
    logic [ROW_W:0]   w_pgdn_sum;
    logic [ROW_W:0]   w_view_lim;
    logic [ROW_W-1:0] w_top_up;

    assign w_rows   = (i_cfg.rows == '0) ? COL_W'(1) : i_cfg.rows;
    assign w_cols   = (i_cfg.cols == '0) ? COL_W'(1) : i_cfg.cols;
    assign w_rows16 = ROW_W'(w_rows);

    // Take a key whenever the result register is free or being emptied.
    assign o_pop = i_key_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        w_pgdn_sum = {1'b0, r_row} + (ROW_W + 1)'(w_rows);
        unique case (i_key)
            KEY_LEFT: begin
                if (r_col != '0) n_col = r_col - 1'b1;
            end
            KEY_RIGHT: begin
                if (({1'b0, r_col} + 1'b1) < {1'b0, w_cols}) n_col = r_col + 1'b1;
            end
            KEY_UP: begin
                if (r_row != '0) n_row = r_row - 1'b1;
            end
            KEY_DOWN: begin
                if (r_row < i_cfg.lines) n_row = r_row + 1'b1;
            end
            KEY_HOME: begin
                n_col = '0;
            end
            KEY_END: begin
                n_col = w_cols - 1'b1;
            end
            KEY_PGUP: begin
                n_row = (r_row > w_rows16) ? r_row - w_rows16 : '0;
            end
            KEY_PGDN: begin
                if (r_row < i_cfg.lines) begin
                    n_row = (w_pgdn_sum > {1'b0, i_cfg.lines}) ? i_cfg.lines
                                                                : w_pgdn_sum[ROW_W-1:0];
                end
            end
            default: begin
            end
        endcase
        // Scroll so that the new row stays in view.
        w_top_up   = (n_row < r_top) ? n_row : r_top;
        w_view_lim = {1'b0, w_top_up} + (ROW_W + 1)'(w_rows);
        n_top      = ({1'b0, n_row} >= w_view_lim) ? n_row - w_rows16 + 1'b1 : w_top_up;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_col <= n_col;
                r_row <= n_row;
                r_top <= n_top;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_key  <= i_key;
            r_quit <= (i_key == KEY_CTRL_Q);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_key;
    assign o_quit       = r_quit;
    assign o_cursor_col = r_col;
    assign o_cursor_row = r_row;
    assign o_top_row    = r_top;

endmodule

// ===== sv/terminal_key_cursor_tracker.sv =====
// Top level of the terminal key cursor tracker: parser, key queue and cursor unit.
//
//   Channel   Direction  Handshake                  Beat contents
//   input     in         i_in_valid / o_in_stall    i_operation, i_in_byte
//   result    out        o_out_valid / i_out_stall  o_key_code, o_quit, o_cursor_col,
//                                                   o_cursor_row, o_top_row
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One input beat can be taken every cycle while the key queue has room. The parser classifies
// a beat in the cycle it is accepted and pushes any completed key into the queue at that
// edge; the cursor unit pops it once the result register is free or being emptied, and
// loads the outcome of that key into the result register as it pops it.
// The sustained rate is one beat per cycle while the result side does not stall.
// Reset is synchronous and active low; it empties the queue, returns the parser to idle,
// zeroes the cursor and view, and loads the register defaults (24 rows, 80 columns, 0 lines).
// A stall on the result side holds the result register; the queue then absorbs keys, and
// o_in_stall rises only once the queue is full.
module terminal_key_cursor_tracker
    import tkc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [7:0]           i_in_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KEY_W-1:0]     o_key_code,
    output logic                 o_quit,
    output logic [COL_W-1:0]     o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [ROW_W-1:0]     o_top_row,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_key_push w_push;
    logic      w_accept;
    logic      w_q_full;
    logic      w_q_valid;
    t_key      w_q_key;
    logic      w_pop;
    logic [COL_W-1:0] w_rows_eff;

    // Configuration registers. Writes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows  <= RESET_ROWS;
            r_cfg.cols  <= RESET_COLS;
            r_cfg.lines <= RESET_LINES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_ROWS:  r_cfg.rows  <= i_cfg_data[COL_W-1:0];
                CFG_IDX_COLS:  r_cfg.cols  <= i_cfg_data[COL_W-1:0];
                CFG_IDX_LINES: r_cfg.lines <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The input side only waits when the key queue has no room left.
    assign o_in_stall = w_q_full;
    assign w_accept   = i_in_valid && !w_q_full;

    tkc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_operation),
        .i_in_byte   (i_in_byte),
        .o_push      (w_push)
    );

    tkc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_key   (w_q_key)
    );

    tkc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_key_valid  (w_q_valid),
        .i_key        (w_q_key),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_code   (o_key_code),
        .o_quit       (o_quit),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_top_row    (o_top_row)
    );

    assign w_rows_eff = (r_cfg.rows == '0) ? COL_W'(1) : r_cfg.rows;

    // The cursor row never lies above the first visible row.
    a_top_not_below_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_top_row <= o_cursor_row))
        else $error("top row is below the cursor row");

    // The cursor row lies inside the visible window after scrolling.
    a_cursor_in_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_cursor_row - o_top_row) < ROW_W'(w_rows_eff)))
        else $error("cursor row is outside the visible window");

    // A Home key always leaves the cursor in the first column.
    a_home_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_code == KEY_HOME) |-> (o_cursor_col == '0))
        else $error("home key left the cursor away from column zero");

    // A full queue is never pushed.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.push && !w_pop) |-> !w_q_full)
        else $error("key pushed into a full queue");

endmodule

// ===== sim/tkc_result_checker.sv =====
// Result checker for the terminal key cursor tracker: predicts every result beat and compares.
module tkc_result_checker
    import tkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_operation,
    input  t_byte                i_in_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_key                 i_key_code,
    input  logic                 i_quit,
    input  logic [COL_W-1:0]     i_cursor_col,
    input  logic [ROW_W-1:0]     i_cursor_row,
    input  logic [ROW_W-1:0]     i_top_row,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_key             key;
        logic             quit;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] top;
    } t_cursor_report;

    t_cursor_report reports_due[$];

    t_phase      seq_phase;
    t_byte       seq_first;
    t_byte       seq_second;
    int unsigned col_now;
    int unsigned row_now;
    int unsigned top_now;
    int unsigned rows_reg;
    int unsigned cols_reg;
    int unsigned lines_reg;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: result mismatch on %s: got %0d, want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // Moves the cursor for one completed key, scrolls the view and queues the result.
    function automatic void track_key(input t_key key);
        int unsigned rows;
        int unsigned cols;
        t_cursor_report rep;
        rows = (rows_reg == 0) ? 1 : rows_reg;
        cols = (cols_reg == 0) ? 1 : cols_reg;
        case (key)
            KEY_LEFT:  if (col_now != 0) col_now--;
            KEY_RIGHT: if (col_now + 1 < cols) col_now++;
            KEY_UP:    if (row_now != 0) row_now--;
            KEY_DOWN:  if (row_now < lines_reg) row_now++;
            KEY_HOME:  col_now = 0;
            KEY_END:   col_now = cols - 1;
            KEY_PGUP:  row_now = (row_now > rows) ? row_now - rows : 0;
            KEY_PGDN: begin
                if (row_now < lines_reg) begin
                    row_now += rows;
                    if (row_now > lines_reg) row_now = lines_reg;
                end
            end
            default: ;
        endcase
        // The sum is formed at full width, so a view near the bottom does not wrap.
        if (row_now < top_now) top_now = row_now;
        if (row_now >= top_now + rows) top_now = row_now - rows + 1;
        rep.key  = key;
        rep.quit = (key == KEY_CTRL_Q);
        rep.col  = col_now[COL_W-1:0];
        rep.row  = row_now[ROW_W-1:0];
        rep.top  = top_now[ROW_W-1:0];
        reports_due.push_back(rep);
    endfunction

    function automatic t_key pair_key(input t_byte a, input t_byte b);
        if (a == BYTE_LBRACKET) begin
            case (b)
                BYTE_A:  return KEY_UP;
                BYTE_B:  return KEY_DOWN;
                BYTE_C:  return KEY_RIGHT;
                BYTE_D:  return KEY_LEFT;
                BYTE_H:  return KEY_HOME;
                BYTE_F:  return KEY_END;
                default: return KEY_ESC;
            endcase
        end
        if (a == BYTE_O && b == BYTE_H) return KEY_HOME;
        if (a == BYTE_O && b == BYTE_F) return KEY_END;
        return KEY_ESC;
    endfunction

    function automatic t_key tilde_key(input t_byte digit);
        case (digit)
            BYTE_DIG_1, BYTE_DIG_7: return KEY_HOME;
            BYTE_DIG_3:             return KEY_DELETE;
            BYTE_DIG_4, BYTE_DIG_8: return KEY_END;
            BYTE_DIG_5:             return KEY_PGUP;
            BYTE_DIG_6:             return KEY_PGDN;
            default:                return KEY_ESC;
        endcase
    endfunction

    // Steps the escape-sequence parser by one accepted input beat.
    function automatic void take_event(input logic op, input t_byte b);
        if (op == OP_TIMEOUT) begin
            if (seq_phase != PH_IDLE) begin
                seq_phase = PH_IDLE;
                track_key(KEY_ESC);
            end
            return;
        end
        case (seq_phase)
            PH_IDLE: begin
                if (b == BYTE_ESC) seq_phase = PH_ESC;
                else track_key({1'b0, b});
            end
            PH_ESC: begin
                seq_first = b;
                seq_phase = PH_FIRST;
            end
            PH_FIRST: begin
                seq_second = b;
                if (seq_first == BYTE_LBRACKET && b >= BYTE_DIG_0 && b <= BYTE_DIG_9) begin
                    seq_phase = PH_DIGIT;
                end else begin
                    seq_phase = PH_IDLE;
                    track_key(pair_key(seq_first, b));
                end
            end
            default: begin
                seq_phase = PH_IDLE;
                track_key((b == BYTE_TILDE) ? tilde_key(seq_second) : KEY_ESC);
            end
        endcase
    endfunction

    task automatic check_report();
        t_cursor_report want;
        if (reports_due.size() == 0) begin
            report_mismatch("key_code with no result due", i_key_code, -1);
            return;
        end
        want = reports_due.pop_front();
        if (i_key_code !== want.key)     report_mismatch("key_code", i_key_code, want.key);
        if (i_quit !== want.quit)        report_mismatch("quit", i_quit, want.quit);
        if (i_cursor_col !== want.col)   report_mismatch("cursor_col", i_cursor_col, want.col);
        if (i_cursor_row !== want.row)   report_mismatch("cursor_row", i_cursor_row, want.row);
        if (i_top_row !== want.top)      report_mismatch("top_row", i_top_row, want.top);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_phase  = PH_IDLE;
            seq_first  = '0;
            seq_second = '0;
            col_now    = 0;
            row_now    = 0;
            top_now    = 0;
            rows_reg   = RESET_ROWS;
            cols_reg   = RESET_COLS;
            lines_reg  = RESET_LINES;
            reports_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_report();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_ROWS:  rows_reg  = i_cfg_data[COL_W-1:0];
                    CFG_IDX_COLS:  cols_reg  = i_cfg_data[COL_W-1:0];
                    CFG_IDX_LINES: lines_reg = i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_event(i_operation, i_in_byte);
        end
        o_pending = reports_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the terminal key cursor tracker: clock, reset, stimulus and verdict.
module tb
    import tkc_pkg::*;
();

    // The block ignores writes to the unused register slot; one is made with every setting.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam t_byte BYTE_CTRL_Q   = 8'h11;
    // Cycles without any beat before the run is declared hung. The longest legitimate
    // quiet stretch is the deliberate receiver hold-off plus a settling pause.
    localparam int    IDLE_LIMIT    = 2000;
    // Settling time after the last result, to cover anything still inside the block.
    localparam int    SETTLE_CYCLES = 8;
    localparam int    HOLD_CYCLES   = 60;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = OP_BYTE;
    t_byte                in_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_key                 key_code;
    logic                 quit;
    logic [COL_W-1:0]     cursor_col;
    logic [ROW_W-1:0]     cursor_row;
    logic [ROW_W-1:0]     top_row;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_ROWS;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int                   fail_count;
    int                   pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int beats_sent = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    logic hold_kick = 1'b0;
    logic hold_kick_seen = 1'b0;

    terminal_key_cursor_tracker dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_operation  (operation),
        .i_in_byte    (in_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_key_code   (key_code),
        .o_quit       (quit),
        .o_cursor_col (cursor_col),
        .o_cursor_row (cursor_row),
        .o_top_row    (top_row),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    tkc_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_operation  (operation),
        .i_in_byte    (in_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_key_code   (key_code),
        .i_quit       (quit),
        .i_cursor_col (cursor_col),
        .i_cursor_row (cursor_row),
        .i_top_row    (top_row),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    // Result side. Stalls are drawn afresh at every falling edge, except during a hold-off,
    // which is counted down here so that the sender keeps offering beats meanwhile and the
    // key queue inside the block fills up and pushes back on the input.
    always @(negedge clk) begin
        if (hold_kick != hold_kick_seen) begin
            hold_kick_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Hang detection: any beat on either channel, or a register write, restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one input beat, starting and ending at a falling edge. Idle cycles before it
    // carry junk on the payload so that only the valid qualifies the data.
    task automatic send_beat(input logic op, input t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid  <= 1'b0;
            operation <= 1'($urandom_range(1));
            in_byte   <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        in_byte   <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_escape(input t_byte a, input t_byte b);
        send_beat(OP_BYTE, BYTE_ESC);
        send_beat(OP_BYTE, a);
        send_beat(OP_BYTE, b);
    endtask

    // Drops valid, lets every expected result come out and the block fall quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all three registers and the spare slot on consecutive edges.
    task automatic write_settings(input logic [CFG_DAT_W-1:0] rows,
                                  input logic [CFG_DAT_W-1:0] cols,
                                  input logic [CFG_DAT_W-1:0] lines);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_ROWS;
        cfg_data  <= rows;
        @(negedge clk);
        cfg_index <= CFG_IDX_COLS;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_index <= CFG_IDX_LINES;
        cfg_data  <= lines;
        @(negedge clk);
        cfg_index <= CFG_IDX_SPARE;
        cfg_data  <= 16'($urandom_range(16'hffff));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random key stroke. Most are well-formed escape sequences with random content; the
    // rest are plain bytes, timeouts and sequences that are cut short or malformed.
    task automatic send_gesture(input int pgdn_pct);
        int    pick;
        t_byte digit;
        pick  = $urandom_range(99);
        digit = BYTE_DIG_0 + 8'($urandom_range(9));
        if ($urandom_range(99) < pgdn_pct) begin
            send_escape(BYTE_LBRACKET, BYTE_DIG_6);
            send_beat(OP_BYTE, BYTE_TILDE);
        end else if (pick < 10) begin
            send_beat(OP_BYTE, 8'($urandom_range(255)));
        end else if (pick < 14) begin
            send_beat(OP_BYTE, BYTE_CTRL_Q);
        end else if (pick < 18) begin
            send_beat(OP_TIMEOUT, 8'($urandom_range(255)));
        end else if (pick < 50) begin
            case ($urandom_range(3))
                0:       send_escape(BYTE_LBRACKET, BYTE_A);
                1:       send_escape(BYTE_LBRACKET, BYTE_B);
                2:       send_escape(BYTE_LBRACKET, BYTE_C);
                default: send_escape(BYTE_LBRACKET, BYTE_D);
            endcase
        end else if (pick < 58) begin
            send_escape($urandom_range(1) ? BYTE_LBRACKET : BYTE_O,
                        $urandom_range(1) ? BYTE_H : BYTE_F);
        end else if (pick < 78) begin
            send_escape(BYTE_LBRACKET, digit);
            send_beat(OP_BYTE, BYTE_TILDE);
        end else if (pick < 86) begin
            // Digit sequence ended by something other than the tilde.
            send_escape(BYTE_LBRACKET, digit);
            if ($urandom_range(1)) send_beat(OP_TIMEOUT, 8'($urandom_range(255)));
            else send_beat(OP_BYTE, 8'($urandom_range(255)));
        end else if (pick < 94) begin
            send_beat(OP_BYTE, BYTE_ESC);
            if ($urandom_range(2) == 0) begin
                send_beat(OP_TIMEOUT, 8'($urandom_range(255)));
            end else begin
                send_beat(OP_BYTE, 8'($urandom_range(255)));
                if ($urandom_range(2) == 0) send_beat(OP_TIMEOUT, 8'($urandom_range(255)));
                else send_beat(OP_BYTE, 8'($urandom_range(255)));
            end
        end else begin
            send_escape(BYTE_LBRACKET, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic [CFG_DAT_W-1:0] rows,
                             input logic [CFG_DAT_W-1:0] cols,
                             input logic [CFG_DAT_W-1:0] lines,
                             input int send_pct, input int recv_pct,
                             input int pgdn_pct, input int beats, input logic pressure);
        int first_beat;
        settle();
        write_settings(rows, cols, lines);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure) hold_kick = ~hold_kick;
        first_beat = beats_sent;
        while (beats_sent - first_beat < beats) send_gesture(pgdn_pct);
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on a tiny screen and a short document with a zero row count,
        // so that every key visibly moves or clamps the cursor.
        write_settings(16'd0, 16'd5, 16'd40);
        send_beat(OP_TIMEOUT, 8'h00);     // timeout while idle gives nothing
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hff);
        send_beat(OP_BYTE, BYTE_CTRL_Q);  // quit flag, cursor stays put
        send_beat(OP_BYTE, BYTE_ESC);     // lone escape closed by a timeout
        send_beat(OP_TIMEOUT, 8'hff);
        send_escape(BYTE_LBRACKET, BYTE_DIG_6);
        send_beat(OP_BYTE, BYTE_TILDE);
        send_escape(BYTE_LBRACKET, BYTE_DIG_5);
        send_beat(OP_BYTE, 8'h78);        // digit sequence without its tilde
        send_escape(BYTE_O, BYTE_F);
        send_escape(BYTE_LBRACKET, 8'h5a);

        // Random phases. The order matters: each phase leaves the cursor outside the limits
        // that the next one sets, so a narrowed screen or a shortened document is seen.
        run_phase(16'd4, 16'd10, 16'd60, 0, 0, 5, 200, 1'b0);
        run_phase(16'd1023, 16'd1, 16'hffff, 52, 0, 75, 300, 1'b0);
        run_phase(16'd1, 16'd1023, 16'd100, 0, 52, 5, 200, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 17, 17, 5, 200, 1'b1);
        // Upper data bits beyond the register widths are set here and must be dropped.
        run_phase(16'ha405, 16'h5c0c, 16'd30, 17, 17, 10, 230, 1'b1);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tkc_pkg.sv
sv/tkc_front.sv
sv/tkc_queue.sv
sv/tkc_back.sv
sv/terminal_key_cursor_tracker.sv
sim/tkc_result_checker.sv
sim/tb.sv
